/* sv/rcpf_pkg.sv */
package rcpf_pkg;

  localparam int TIME_BITS   = 32;
  localparam int SAMPLE_BITS = 10;

  localparam int WIDTH_BITS = 16;
  localparam int GAP_BITS   = 20;
  localparam int LEVEL_BITS = SAMPLE_BITS;
  localparam int CFG_BITS   = 20;
  localparam int IDX_BITS   = 3;

  localparam int IN_BITS   = 1 + SAMPLE_BITS;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int OUT_BITS  = 5;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_CHARGE = 2'd1,
    PH_FIRE   = 2'd2
  } phase_t;

  typedef enum logic [IDX_BITS-1:0] {
    REG_WIDTH_MIN     = 3'd0,
    REG_WIDTH_MAX     = 3'd1,
    REG_GAP_MIN       = 3'd2,
    REG_GAP_MAX       = 3'd3,
    REG_TRIGGER_WIDTH = 3'd4,
    REG_FIRE_LEVEL    = 3'd5,
    REG_SAFE_LEVEL    = 3'd6
  } reg_idx_t;

  localparam logic [WIDTH_BITS-1:0] WIDTH_MIN_RST     = WIDTH_BITS'(500);
  localparam logic [WIDTH_BITS-1:0] WIDTH_MAX_RST     = WIDTH_BITS'(2500);
  localparam logic [GAP_BITS-1:0]   GAP_MIN_RST       = GAP_BITS'(3000);
  localparam logic [GAP_BITS-1:0]   GAP_MAX_RST       = GAP_BITS'(100000);
  localparam logic [WIDTH_BITS-1:0] TRIGGER_WIDTH_RST = WIDTH_BITS'(1700);
  localparam logic [LEVEL_BITS-1:0] FIRE_LEVEL_RST    = LEVEL_BITS'(348);
  localparam logic [LEVEL_BITS-1:0] SAFE_LEVEL_RST    = LEVEL_BITS'(21);

  typedef struct packed {
    logic [WIDTH_BITS-1:0] width_min;
    logic [WIDTH_BITS-1:0] width_max;
    logic [GAP_BITS-1:0]   gap_min;
    logic [GAP_BITS-1:0]   gap_max;
    logic [WIDTH_BITS-1:0] trigger_width;
    logic [LEVEL_BITS-1:0] fire_level;
    logic [LEVEL_BITS-1:0] safe_level;
  } cfg_t;

  typedef struct packed {
    phase_t mode;
    logic   indicator_on;
    logic   fire_on;
    logic   charge_on;
  } res_t;

endpackage

/* sv/rcpf_tick.sv */
module rcpf_tick (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             rc_level,
  input  rcpf_pkg::sample_t cap_sample,
  input  rcpf_pkg::cfg_t   cfg,
  output rcpf_pkg::res_t   res,
  output rcpf_pkg::phase_t phase
);
  import rcpf_pkg::*;

  time_t  now_us, rise_time, fall_time, low_gap, high_width;
  time_t  rise_time_next, fall_time_next, low_gap_next, high_width_next;
  time_t  last_edge, activity;
  time_t  width_min_x, width_max_x, gap_min_x, gap_max_x, trigger_x;
  logic   prev_level;
  logic   pulse_ok;
  phase_t phase_next;

  assign width_min_x = TIME_BITS'(cfg.width_min);
  assign width_max_x = TIME_BITS'(cfg.width_max);
  assign gap_min_x   = TIME_BITS'(cfg.gap_min);
  assign gap_max_x   = TIME_BITS'(cfg.gap_max);
  assign trigger_x   = TIME_BITS'(cfg.trigger_width);

  always_comb begin
    rise_time_next  = rise_time;
    fall_time_next  = fall_time;
    low_gap_next    = low_gap;
    high_width_next = high_width;
    if (!prev_level && rc_level) begin
      rise_time_next = now_us;
      low_gap_next   = now_us - fall_time;
    end else if (prev_level && !rc_level) begin
      fall_time_next  = now_us;
      high_width_next = now_us - rise_time;
    end
    last_edge = (rise_time_next > fall_time_next) ? rise_time_next : fall_time_next;
    activity  = now_us - last_edge;
    pulse_ok  = (low_gap_next >= gap_min_x) && (low_gap_next <= gap_max_x) &&
                (high_width_next >= width_min_x) && (high_width_next <= width_max_x) &&
                (activity <= gap_max_x) && (high_width_next > trigger_x);

    phase_next = phase;
    unique case (phase)
      PH_CHARGE: if (cap_sample > cfg.fire_level) phase_next = PH_FIRE;
      PH_FIRE:   if (cap_sample < cfg.safe_level) phase_next = PH_IDLE;
      default:   phase_next = pulse_ok ? PH_CHARGE : PH_IDLE;
    endcase

    res.mode         = phase_next;
    res.charge_on    = (phase_next == PH_CHARGE);
    res.fire_on      = (phase_next == PH_FIRE);
    res.indicator_on = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_us     <= '0;
      rise_time  <= '0;
      fall_time  <= '0;
      low_gap    <= '0;
      high_width <= '0;
      prev_level <= 1'b0;
      phase      <= PH_IDLE;
    end else if (step) begin
      now_us     <= now_us + TIME_BITS'(1);
      rise_time  <= rise_time_next;
      fall_time  <= fall_time_next;
      low_gap    <= low_gap_next;
      high_width <= high_width_next;
      prev_level <= rc_level;
      phase      <= phase_next;
    end
  end

endmodule

/* sv/rc_pulse_charge_fire_controller_unit.sv */
// channel  dir  handshake          payload (lowest bit up)
// s_*      in   s_tvalid/s_tready  s_tdata: rc_level, cap_sample
// m_*      out  m_tvalid/m_tready  m_tdata: charge_on, fire_on, indicator_on, mode
// cfg_*    in   cfg_we             cfg_index, cfg_data
//
// One tick per cycle sustained while m_tready allows; a tick's result reaches m_tdata through
// the input register, then the result register.
// The edge timing, gap/width compares and phase rule sit between those two registers.
// rst is synchronous: clears the tick clock, edge stamps and phase; registers take defaults.
// A stalled result holds the input register; a new tick is taken while the result waits
// only if the input register is empty.
module rc_pulse_charge_fire_controller_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [8*rcpf_pkg::IN_BYTES-1:0]     s_tdata,   // rc_level, cap_sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [8*rcpf_pkg::OUT_BYTES-1:0]    m_tdata,   // charge_on, fire_on, indicator_on, mode
  input  logic                                cfg_we,
  input  logic [rcpf_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [rcpf_pkg::CFG_BITS-1:0]       cfg_data
);
  import rcpf_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  logic    in_level;
  sample_t in_sample;
  logic    advance, step;
  res_t    res;
  phase_t  phase;

  assign advance  = !m_tvalid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_min     <= WIDTH_MIN_RST;
      cfg.width_max     <= WIDTH_MAX_RST;
      cfg.gap_min       <= GAP_MIN_RST;
      cfg.gap_max       <= GAP_MAX_RST;
      cfg.trigger_width <= TRIGGER_WIDTH_RST;
      cfg.fire_level    <= FIRE_LEVEL_RST;
      cfg.safe_level    <= SAFE_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_WIDTH_MIN:     cfg.width_min     <= cfg_data[WIDTH_BITS-1:0];
        REG_WIDTH_MAX:     cfg.width_max     <= cfg_data[WIDTH_BITS-1:0];
        REG_GAP_MIN:       cfg.gap_min       <= cfg_data[GAP_BITS-1:0];
        REG_GAP_MAX:       cfg.gap_max       <= cfg_data[GAP_BITS-1:0];
        REG_TRIGGER_WIDTH: cfg.trigger_width <= cfg_data[WIDTH_BITS-1:0];
        REG_FIRE_LEVEL:    cfg.fire_level    <= cfg_data[LEVEL_BITS-1:0];
        REG_SAFE_LEVEL:    cfg.safe_level    <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (step) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_level  <= s_tdata[0];
      in_sample <= s_tdata[SAMPLE_BITS:1];
    end
  end

  rcpf_tick u_tick (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .rc_level   (in_level),
    .cap_sample (in_sample),
    .cfg        (cfg),
    .res        (res),
    .phase      (phase)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= (8*OUT_BYTES)'(res);
    end
  end

  a_in_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("pending tick dropped while result stalled");

  a_step_out: assert property (@(posedge clk) disable iff (rst)
    step |=> m_tvalid)
    else $error("processed tick produced no result");

  a_take_in: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted transaction not captured");

  a_no_skip: assert property (@(posedge clk) disable iff (rst)
    $past(phase) == PH_IDLE |-> phase != PH_FIRE)
    else $error("phase jumped from idle to firing");

endmodule
